// File: design/blramp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blramp_pkg
// Shared types, constants and curve functions for the backlight ramp block.
// ----------------------------------------------------------------------------
package blramp_pkg;

    localparam int CURVE_ENTRIES_DEF = 2048;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_LUX_OFFSET    = 2'd0;
    localparam logic [1:0] REG_ABSENT_LEVEL  = 2'd1;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

    localparam logic [15:0] LUX_OFFSET_RST    = 16'd1;
    localparam logic [7:0]  ABSENT_LEVEL_RST  = 8'd5;
    localparam logic [7:0]  SAMPLE_PERIOD_RST = 8'd10;

    localparam logic [7:0] LEVEL_INIT  = 8'd128;
    localparam logic [7:0] LEVEL_MAX   = 8'd255;
    localparam logic [7:0] CURVE_FLOOR = 8'd10;
    localparam logic [7:0] STEP_MIN    = 8'd1;
    localparam logic [7:0] STEP_KNEE   = 8'd20;

    // x/10 = (x*205)>>11 and x/20 = (x*205)>>12, exact for 8-bit x
    localparam logic [7:0] RECIP_10 = 8'd205;

    localparam int unsigned MAX_K     = 245;
    localparam int unsigned EXP_Q16   = 30233;
    localparam int unsigned LOG2A_Q16 = 214425;

    typedef struct packed {
        logic [15:0] lux_raw;
        logic        presence;
    } t_in;

    typedef struct packed {
        logic [7:0] level;
        logic       changed;
        logic [7:0] goal_level;
    } t_out;

    typedef struct packed {
        logic [15:0] lux_offset;
        logic [7:0]  absent_level;
        logic [7:0]  sample_period;
    } t_cfg;

    typedef struct packed {
        logic sample;
        logic use_absent;
        logic over;
    } t_sample_ctl;

    function automatic logic [31:0] log2_q16(input logic [15:0] x);
        logic [63:0] m;
        logic [31:0] r;
        int          n;
        n = 0;
        r = '0;
        if (x == '0) begin
            return '0;
        end
        for (int b = 0; b < 16; b++) begin
            if (x[b]) begin
                n = b;
            end
        end
        m = 64'(x) << (30 - n);
        r = 32'(n) << 16;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'h0000_0000_8000_0000) begin
                m = m >> 1;
                r[15 - i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] curve_entry(input logic [16:0] l);
        logic [63:0] t;
        int unsigned k;
        int unsigned cand;
        k = 0;
        cand = 0;
        if (l == '0) begin
            return CURVE_FLOOR;
        end
        t = ((64'(log2_q16(l[15:0])) * 64'(EXP_Q16)) >> 16) + 64'(LOG2A_Q16);
        for (int bit_w = 128; bit_w >= 1; bit_w = bit_w / 2) begin
            cand = k + bit_w;
            if (cand <= MAX_K && 64'(log2_q16(16'(cand))) <= t) begin
                k = cand;
            end
        end
        return 8'(k) + CURVE_FLOOR;
    endfunction

endpackage

// File: design/blramp_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blramp_regs
// APB configuration registers: lux offset, absent level, sample period.
// ----------------------------------------------------------------------------
module blramp_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blramp_pkg::APB_AW-1:0] paddr,
    input  logic [blramp_pkg::APB_DW-1:0] pwdata,
    output logic [blramp_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    output blramp_pkg::t_cfg              o_cfg
);

    blramp_pkg::t_cfg r_cfg;
    logic [1:0]       w_idx;
    logic             w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lux_offset    <= blramp_pkg::LUX_OFFSET_RST;
            r_cfg.absent_level  <= blramp_pkg::ABSENT_LEVEL_RST;
            r_cfg.sample_period <= blramp_pkg::SAMPLE_PERIOD_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                blramp_pkg::REG_LUX_OFFSET:    r_cfg.lux_offset    <= pwdata[15:0];
                blramp_pkg::REG_ABSENT_LEVEL:  r_cfg.absent_level  <= pwdata[7:0];
                blramp_pkg::REG_SAMPLE_PERIOD: r_cfg.sample_period <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            blramp_pkg::REG_LUX_OFFSET:    prdata = 32'(r_cfg.lux_offset);
            blramp_pkg::REG_ABSENT_LEVEL:  prdata = 32'(r_cfg.absent_level);
            blramp_pkg::REG_SAMPLE_PERIOD: prdata = 32'(r_cfg.sample_period);
            default:                       prdata = '0;
        endcase
    end

endmodule

// File: design/blramp_curve_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blramp_curve_rom
// Brightness curve ROM, contents computed at elaboration, registered read.
// ----------------------------------------------------------------------------
module blramp_curve_rom #(
    parameter int CURVE_ENTRIES = blramp_pkg::CURVE_ENTRIES_DEF,
    parameter int AW            = $clog2(CURVE_ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr,
    output logic [7:0]    o_data
);

    typedef logic [7:0] t_rom [CURVE_ENTRIES];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int l = 0; l < CURVE_ENTRIES; l++) begin
            rom[l] = blramp_pkg::curve_entry(17'(l));
        end
        return rom;
    endfunction

    localparam t_rom CURVE = build_rom();

    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= CURVE[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// File: design/blramp_sample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blramp_sample
// Input register, tick counter and offset lux; issues the curve lookup.
// ----------------------------------------------------------------------------
module blramp_sample #(
    parameter int CURVE_ENTRIES = blramp_pkg::CURVE_ENTRIES_DEF,
    parameter int AW            = $clog2(CURVE_ENTRIES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  blramp_pkg::t_in               i_in_data,
    input  blramp_pkg::t_cfg              i_cfg,
    input  logic                          i_s2_ready,
    output logic                          o_s2_valid,
    output blramp_pkg::t_sample_ctl       o_s2_ctl,
    output logic                          o_rom_en,
    output logic [AW-1:0]                 o_rom_addr
);

    logic                    r_in_valid;
    blramp_pkg::t_in         r_in;
    logic                    r_s2_valid;
    blramp_pkg::t_sample_ctl r_s2_ctl;
    logic [7:0]              r_tick;
    logic [7:0]              n_tick;
    blramp_pkg::t_sample_ctl n_ctl;
    logic [15:0]             w_lux;
    logic                    w_en1;
    logic                    w_en2;

    assign w_en2      = !r_s2_valid || i_s2_ready;
    assign w_en1      = !r_in_valid || w_en2;
    assign o_in_ready = w_en1;
    assign o_s2_valid = r_s2_valid;
    assign o_s2_ctl   = r_s2_ctl;
    assign o_rom_en   = w_en2;

    always_comb begin
        n_ctl.sample     = (r_tick >= i_cfg.sample_period);
        n_ctl.use_absent = !r_in.presence;
        w_lux = (r_in.lux_raw > i_cfg.lux_offset) ? (r_in.lux_raw - i_cfg.lux_offset) : '0;
        n_ctl.over = ({1'b0, w_lux} >= 17'(CURVE_ENTRIES));
        o_rom_addr = n_ctl.over ? '0 : w_lux[AW-1:0];
        n_tick = n_ctl.sample ? '0 : r_tick + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_tick     <= '0;
        end else begin
            if (w_en1) begin
                r_in_valid <= i_in_valid;
            end
            if (w_en2) begin
                r_s2_valid <= r_in_valid;
            end
            if (w_en2 && r_in_valid) begin
                r_tick <= n_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_en2) begin
            r_s2_ctl <= n_ctl;
        end
    end

endmodule

// File: design/blramp_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blramp_ramp
// Target select, level step toward target, and result register.
// ----------------------------------------------------------------------------
module blramp_ramp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s2_valid,
    output logic                    o_s2_ready,
    input  blramp_pkg::t_sample_ctl i_s2_ctl,
    input  logic [7:0]              i_rom_data,
    input  logic [7:0]              i_absent_level,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output blramp_pkg::t_out        o_out_data
);

    logic             r_out_valid;
    blramp_pkg::t_out r_out;
    logic [7:0]       r_current;
    logic [7:0]       r_target;
    logic [7:0]       n_current;
    logic [7:0]       n_target;
    logic             n_changed;
    logic [7:0]       w_diff;
    logic [15:0]      w_prod;
    logic [7:0]       w_tenth;
    logic [7:0]       w_step;
    logic             w_en;
    logic             w_fire;

    assign w_en        = !r_out_valid || i_out_ready;
    assign w_fire      = i_s2_valid && w_en;
    assign o_s2_ready  = w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_target = r_target;
        if (i_s2_ctl.sample) begin
            if (i_s2_ctl.use_absent) begin
                n_target = i_absent_level;
            end else if (i_s2_ctl.over) begin
                n_target = blramp_pkg::LEVEL_MAX;
            end else begin
                n_target = i_rom_data;
            end
        end
        w_diff  = (n_target > r_current) ? n_target - r_current : r_current - n_target;
        w_prod  = 16'(r_current) * 16'(blramp_pkg::RECIP_10);
        w_tenth = 8'(w_prod >> 11);
        w_step  = (r_current < blramp_pkg::STEP_KNEE) ? blramp_pkg::STEP_MIN
                                                      : 8'(w_prod >> 12);
        n_current = r_current;
        n_changed = 1'b0;
        if (w_diff > w_tenth) begin
            n_changed = 1'b1;
            if (r_current < n_target) begin
                n_current = (w_diff > w_step) ? r_current + w_step : n_target;
            end else begin
                n_current = (w_diff > w_step) ? r_current - w_step : n_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_current   <= blramp_pkg::LEVEL_INIT;
            r_target    <= blramp_pkg::LEVEL_INIT;
        end else begin
            if (w_en) begin
                r_out_valid <= i_s2_valid;
            end
            if (w_fire) begin
                r_current <= n_current;
                r_target  <= n_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.level      <= n_current;
            r_out.changed    <= n_changed;
            r_out.goal_level <= n_target;
        end
    end

endmodule

// File: design/backlight_auto_brightness_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backlight_auto_brightness_ramp
// Ambient-light driven backlight level with a smooth per-tick ramp.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, i_in_data): one transaction per timer
// tick with a raw lux reading and a presence bit. Output channel
// (o_out_valid/i_out_ready, o_out_data): one transaction per tick with the
// new level, a changed flag and the goal level.
// Input register, curve ROM read and result register form three stages;
// one tick is taken every cycle while the receiver accepts results, limited
// only by the level update loop, which closes within the result stage.
// Configuration through the APB port: lux_offset at 0x0, absent_level at
// 0x4, sample_period at 0x8; write only while no tick is in flight.
// Reset: tick count 0, level and goal 128, registers to 1, 5 and 10.
// Receiver stall: the result register holds, bubbles in front of it fill,
// and o_in_ready drops once all three stages are occupied.
// ----------------------------------------------------------------------------
module backlight_auto_brightness_ramp #(
    parameter int CURVE_ENTRIES = blramp_pkg::CURVE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  blramp_pkg::t_in               i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output blramp_pkg::t_out              o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blramp_pkg::APB_AW-1:0] paddr,
    input  logic [blramp_pkg::APB_DW-1:0] pwdata,
    output logic [blramp_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);

    localparam int AW = $clog2(CURVE_ENTRIES);

    blramp_pkg::t_cfg        w_cfg;
    logic                    w_s2_valid;
    logic                    w_s2_ready;
    blramp_pkg::t_sample_ctl w_s2_ctl;
    logic                    w_rom_en;
    logic [AW-1:0]           w_rom_addr;
    logic [7:0]              w_rom_data;

    blramp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    blramp_sample #(
        .CURVE_ENTRIES (CURVE_ENTRIES),
        .AW            (AW)
    ) u_sample (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (w_cfg),
        .i_s2_ready (w_s2_ready),
        .o_s2_valid (w_s2_valid),
        .o_s2_ctl   (w_s2_ctl),
        .o_rom_en   (w_rom_en),
        .o_rom_addr (w_rom_addr)
    );

    blramp_curve_rom #(
        .CURVE_ENTRIES (CURVE_ENTRIES),
        .AW            (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_rom_en),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    blramp_ramp u_ramp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s2_valid     (w_s2_valid),
        .o_s2_ready     (w_s2_ready),
        .i_s2_ctl       (w_s2_ctl),
        .i_rom_data     (w_rom_data),
        .i_absent_level (w_cfg.absent_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_data     (o_out_data)
    );

endmodule
